// ===== rtl/gba_pkg.sv =====
// ----------------------------------------------------------------------------
// gba_pkg
// Shared constants and types of the group-by aggregation engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gba_pkg;

  // Aggregate function codes held in the function registers.
  localparam logic [2:0] FN_COUNT = 3'd0;
  localparam logic [2:0] FN_SUM   = 3'd1;
  localparam logic [2:0] FN_AVG   = 3'd2;
  localparam logic [2:0] FN_MIN   = 3'd3;
  localparam logic [2:0] FN_MAX   = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_FUNC0 = 3'd0;
  localparam logic [2:0] REG_FUNC1 = 3'd1;
  localparam logic [2:0] REG_FUNC2 = 3'd2;
  localparam logic [2:0] REG_FUNC3 = 3'd3;
  localparam logic [2:0] REG_SLOTS = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_GROUP = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Request types.
  localparam logic REQ_ROW  = 1'b0;
  localparam logic REQ_EMIT = 1'b1;

  // Key search lanes: group g lives in lane g % KEY_LANES.
  localparam int KEY_LANES = 4;
  localparam int LANE_W    = 2;

  // Average: 64-bit magnitude with 16 fraction bits, one quotient bit a step.
  localparam int DIV_STEPS = 80;
  localparam int STEP_W    = 7;

  // Control bundle from the sequencer to every slot lane.
  typedef struct packed {
    logic rd;          // read the group's slot entry
    logic wr;          // write back the updated entry
    logic fresh;       // the group is new: old entry reads as zero
    logic div_start;   // load the divider from the read entry
    logic div_step;    // one divider step
  } slot_ctrl_t;

endpackage : gba_pkg

`default_nettype wire

// ===== rtl/group_by_aggregation_engine.sv =====
// ----------------------------------------------------------------------------
// group_by_aggregation_engine
// Hash-free group-by aggregation over a first-seen ordered group table.
// ----------------------------------------------------------------------------
// A row searches the group table in steps, each step comparing four stored
// keys in parallel, so up to ceil(groups/4) steps (at least one), then reads
// and writes its slots; busy stays high from the start beat until that write,
// and no new row is taken while busy. An emit reads each group's slots, loads
// and runs the 80-step average divider, and each group's result shows
// for one cycle on out_valid_o; an empty emit answers in the cycle after
// start, and a dropped row in the cycle after its last search step. The
// receiver cannot stall results. No clearing pass runs after reset; the
// block is ready at once.
`default_nettype none

module group_by_aggregation_engine #(
  parameter int MAX_GROUPS = 64,
  parameter int NUM_SLOTS  = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [2:0]  cfg_data_i,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type_i,
  input  wire logic [63:0] group_key_i,
  input  wire logic [31:0] arg_value0_i,
  input  wire logic [31:0] arg_value1_i,
  input  wire logic [31:0] arg_value2_i,
  input  wire logic [31:0] arg_value3_i,
  input  wire logic        arg_null0_i,
  input  wire logic        arg_null1_i,
  input  wire logic        arg_null2_i,
  input  wire logic        arg_null3_i,
  output logic             out_valid_o,
  output logic [1:0]       status_o,
  output logic [63:0]      out_key_o,
  output logic [63:0]      out_result0_o,
  output logic [63:0]      out_result1_o,
  output logic [63:0]      out_result2_o,
  output logic [63:0]      out_result3_o,
  output logic             out_null0_o,
  output logic             out_null1_o,
  output logic             out_null2_o,
  output logic             out_null3_o,
  output logic             last_of_run_o
);
  import gba_pkg::*;

  localparam int CW    = $clog2(MAX_GROUPS + 1);
  localparam int IW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int DEPTH = (MAX_GROUPS + KEY_LANES - 1) / KEY_LANES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW    = AW + LANE_W + CW;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_CMP, S_UPD_RD, S_UPD_WR, S_E_RD, S_E_LD, S_E_DIV, S_E_OUT
  } state_e;

  state_e          state_q;
  logic [2:0]      func_q [4];
  logic [2:0]      slots_q;
  logic [CW-1:0]   total_q;
  logic [CW-1:0]   emit_q;
  logic [AW-1:0]   addr_q;
  logic [IW-1:0]   grp_q;
  logic            fresh_q;
  logic [STEP_W-1:0] step_q;
  logic [63:0]     key_q;
  logic [31:0]     val_q [4];
  logic            nul_q [4];

  logic            ov_q;
  logic [1:0]      st_q;
  logic [63:0]     okey_q;
  logic [63:0]     ores_q [4];
  logic            onul_q [4];
  logic            olast_q;

  logic [2:0]      n_act;
  logic [CW+1:0]   tot_x;
  logic [CW+1:0]   emit_x;
  logic [KEY_LANES-1:0] hit;
  logic [63:0]     lane_key [KEY_LANES];
  logic            any_hit;
  logic [LANE_W-1:0] hit_lane;
  logic            last_step;
  logic            key_wr;
  logic            key_rd;
  logic [AW-1:0]   key_rd_addr;
  slot_ctrl_t      sctrl;
  logic [63:0]     res_w [4];
  logic            nul_w [4];

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign n_act       = (slots_q > 3'(NUM_SLOTS)) ? 3'(NUM_SLOTS) : slots_q;
  assign tot_x       = (CW + 2)'(total_q);
  assign emit_x      = (CW + 2)'(emit_q);

  // Key bank read: search address, or the bank row of the group being emitted.
  assign key_rd      = (state_q == S_SRCH) || (state_q == S_E_RD);
  assign key_rd_addr = (state_q == S_E_RD) ? AW'(emit_x >> LANE_W) : addr_q;
  assign last_step   = (WW'({addr_q, {LANE_W{1'b1}}}) + WW'(1)) >= WW'(total_q);
  assign key_wr      = (state_q == S_CMP) && !any_hit && last_step &&
                       (total_q != CW'(MAX_GROUPS));

  // Key search lanes.
  for (genvar l = 0; l < KEY_LANES; l++) begin : g_key
    logic cmp_ok;
    assign cmp_ok = WW'({addr_q, LANE_W'(l)}) < WW'(total_q);
    gba_key_lane #(
      .DEPTH (DEPTH),
      .AW    (AW)
    ) u_key (
      .clk_i     (clk_i),
      .wr_en_i   (key_wr && (tot_x[LANE_W-1:0] == LANE_W'(l))),
      .wr_addr_i (AW'(tot_x >> LANE_W)),
      .wr_key_i  (key_q),
      .rd_en_i   (key_rd),
      .rd_addr_i (key_rd_addr),
      .cmp_key_i (key_q),
      .cmp_ok_i  (cmp_ok),
      .hit_o     (hit[l]),
      .rd_key_o  (lane_key[l])
    );
  end

  // Merge: the lowest lane that hits holds the earliest group.
  always_comb begin
    any_hit  = |hit;
    hit_lane = '0;
    for (int l = KEY_LANES - 1; l >= 0; l--) begin
      if (hit[l]) begin
        hit_lane = LANE_W'(l);
      end
    end
  end

  // Slot lane control from the sequencer state.
  always_comb begin
    sctrl.rd        = (state_q == S_UPD_RD) || (state_q == S_E_RD);
    sctrl.wr        = (state_q == S_UPD_WR);
    sctrl.fresh     = fresh_q;
    sctrl.div_start = (state_q == S_E_LD);
    sctrl.div_step  = (state_q == S_E_DIV);
  end

  // Aggregate slot lanes.
  for (genvar s = 0; s < 4; s++) begin : g_slot
    if (s < NUM_SLOTS) begin : g_on
      gba_slot_lane #(
        .MAX_GROUPS (MAX_GROUPS),
        .IW         (IW)
      ) u_slot (
        .clk_i    (clk_i),
        .ctrl_i   (sctrl),
        .active_i (3'(s) < n_act),
        .fn_i     (func_q[s]),
        .addr_i   ((state_q == S_E_RD) ? IW'(emit_q) : grp_q),
        .value_i  (val_q[s]),
        .null_i   (nul_q[s]),
        .result_o (res_w[s]),
        .null_o   (nul_w[s])
      );
    end else begin : g_off
      assign res_w[s] = 64'd0;
      assign nul_w[s] = 1'b0;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        func_q[i] <= FN_COUNT;
      end
      slots_q <= 3'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FUNC0: func_q[0] <= cfg_data_i;
        REG_FUNC1: func_q[1] <= cfg_data_i;
        REG_FUNC2: func_q[2] <= cfg_data_i;
        REG_FUNC3: func_q[3] <= cfg_data_i;
        REG_SLOTS: slots_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input beat capture.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      key_q    <= group_key_i;
      val_q[0] <= arg_value0_i;
      val_q[1] <= arg_value1_i;
      val_q[2] <= arg_value2_i;
      val_q[3] <= arg_value3_i;
      nul_q[0] <= arg_null0_i;
      nul_q[1] <= arg_null1_i;
      nul_q[2] <= arg_null2_i;
      nul_q[3] <= arg_null3_i;
    end
  end

  // Sequencer and registered result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      emit_q  <= '0;
      addr_q  <= '0;
      grp_q   <= '0;
      fresh_q <= 1'b0;
      step_q  <= '0;
      ov_q    <= 1'b0;
      st_q    <= ST_GROUP;
      okey_q  <= '0;
      olast_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        ores_q[i] <= '0;
        onul_q[i] <= 1'b0;
      end
    end else begin
      ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            addr_q <= '0;
            emit_q <= '0;
            if (req_type_i == REQ_ROW) begin
              state_q <= S_SRCH;
            end else if (total_q == '0) begin
              ov_q    <= 1'b1;
              st_q    <= ST_EMPTY;
              okey_q  <= '0;
              olast_q <= 1'b1;
              for (int i = 0; i < 4; i++) begin
                ores_q[i] <= '0;
                onul_q[i] <= 1'b0;
              end
            end else begin
              state_q <= S_E_RD;
            end
          end
        end
        S_SRCH: state_q <= S_CMP;
        S_CMP: begin
          if (any_hit) begin
            grp_q   <= IW'({addr_q, hit_lane});
            fresh_q <= 1'b0;
            state_q <= S_UPD_RD;
          end else if (!last_step) begin
            addr_q  <= addr_q + AW'(1);
            state_q <= S_SRCH;
          end else if (total_q == CW'(MAX_GROUPS)) begin
            ov_q    <= 1'b1;
            st_q    <= ST_FULL;
            okey_q  <= '0;
            olast_q <= 1'b1;
            for (int i = 0; i < 4; i++) begin
              ores_q[i] <= '0;
              onul_q[i] <= 1'b0;
            end
            state_q <= S_IDLE;
          end else begin
            grp_q   <= IW'(total_q);
            fresh_q <= 1'b1;
            total_q <= total_q + CW'(1);
            state_q <= S_UPD_RD;
          end
        end
        S_UPD_RD: state_q <= S_UPD_WR;
        S_UPD_WR: state_q <= S_IDLE;
        S_E_RD:   state_q <= S_E_LD;
        S_E_LD: begin
          step_q  <= '0;
          state_q <= S_E_DIV;
        end
        S_E_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIV_STEPS - 1)) begin
            state_q <= S_E_OUT;
          end
        end
        S_E_OUT: begin
          ov_q    <= 1'b1;
          st_q    <= ST_GROUP;
          okey_q  <= lane_key[emit_x[LANE_W-1:0]];
          olast_q <= (emit_q + CW'(1)) == total_q;
          for (int i = 0; i < 4; i++) begin
            ores_q[i] <= res_w[i];
            onul_q[i] <= nul_w[i];
          end
          if ((emit_q + CW'(1)) == total_q) begin
            total_q <= '0;
            emit_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            emit_q  <= emit_q + CW'(1);
            state_q <= S_E_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = ov_q;
  assign status_o      = st_q;
  assign out_key_o     = okey_q;
  assign out_result0_o = ores_q[0];
  assign out_result1_o = ores_q[1];
  assign out_result2_o = ores_q[2];
  assign out_result3_o = ores_q[3];
  assign out_null0_o   = onul_q[0];
  assign out_null1_o   = onul_q[1];
  assign out_null2_o   = onul_q[2];
  assign out_null3_o   = onul_q[3];
  assign last_of_run_o = olast_q;

endmodule : group_by_aggregation_engine

`default_nettype wire

// ===== rtl/gba_key_lane.sv =====
// ----------------------------------------------------------------------------
// gba_key_lane
// One bank of the group key table with its own key comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module gba_key_lane #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [63:0]   wr_key_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  input  wire logic [63:0]   cmp_key_i,
  input  wire logic          cmp_ok_i,
  output logic               hit_o,
  output logic [63:0]        rd_key_o
);
  import gba_pkg::*;

  logic [63:0] mem_q [DEPTH];
  logic [63:0] rd_q;

  // Key storage with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_key_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // The entry matches when it holds a live group with the same key.
  assign hit_o    = cmp_ok_i && (rd_q == cmp_key_i);
  assign rd_key_o = rd_q;

endmodule : gba_key_lane

`default_nettype wire

// ===== rtl/gba_slot_lane.sv =====
// ----------------------------------------------------------------------------
// gba_slot_lane
// One aggregate slot: per-group state memory, update logic and the
// bit-serial divider that forms the average.
// ----------------------------------------------------------------------------
`default_nettype none

module gba_slot_lane #(
  parameter int MAX_GROUPS = 64,
  parameter int IW         = 6
) (
  input  wire logic                clk_i,
  input  wire gba_pkg::slot_ctrl_t ctrl_i,
  input  wire logic                active_i,
  input  wire logic [2:0]          fn_i,
  input  wire logic [IW-1:0]       addr_i,
  input  wire logic [31:0]         value_i,
  input  wire logic                null_i,
  output logic [63:0]              result_o,
  output logic                     null_o
);
  import gba_pkg::*;

  logic [31:0] cnt_mem [MAX_GROUPS];
  logic [63:0] sum_mem [MAX_GROUPS];
  logic [31:0] ext_mem [MAX_GROUPS];
  logic        hv_mem  [MAX_GROUPS];

  logic [31:0] cnt_q;
  logic [63:0] sum_q;
  logic [31:0] ext_q;
  logic        hv_q;

  logic [31:0] old_cnt, cnt_n;
  logic [63:0] old_sum, sum_n;
  logic [31:0] old_ext, ext_n;
  logic        old_hv, hv_n;
  logic [31:0] cnt_inc;
  logic [64:0] sum_x;
  logic [63:0] sum_sat;

  logic [79:0] dq_q;
  logic [31:0] rem_q;
  logic [32:0] trial;
  logic        ge;
  logic [63:0] limit;
  logic [63:0] mag_res;
  logic        neg;

  // State memories, read into registers, written back after an update.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      cnt_q <= cnt_mem[addr_i];
      sum_q <= sum_mem[addr_i];
      ext_q <= ext_mem[addr_i];
      hv_q  <= hv_mem[addr_i];
    end
    if (ctrl_i.wr && (active_i || ctrl_i.fresh)) begin
      cnt_mem[addr_i] <= cnt_n;
      sum_mem[addr_i] <= sum_n;
      ext_mem[addr_i] <= ext_n;
      hv_mem[addr_i]  <= hv_n;
    end
  end

  // Old entry: a new group starts from zero.
  always_comb begin
    old_cnt = ctrl_i.fresh ? 32'd0 : cnt_q;
    old_sum = ctrl_i.fresh ? 64'd0 : sum_q;
    old_ext = ctrl_i.fresh ? 32'd0 : ext_q;
    old_hv  = ctrl_i.fresh ? 1'b0  : hv_q;
  end

  // Saturating count and sum.
  assign cnt_inc = (old_cnt == 32'hFFFF_FFFF) ? old_cnt : old_cnt + 32'd1;
  assign sum_x   = {old_sum[63], old_sum} + {{33{value_i[31]}}, value_i};
  always_comb begin
    if (sum_x[64] != sum_x[63]) begin
      sum_sat = sum_x[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      sum_sat = sum_x[63:0];
    end
  end

  // Slot update for one row.
  always_comb begin
    cnt_n = old_cnt;
    sum_n = old_sum;
    ext_n = old_ext;
    hv_n  = old_hv;
    if (active_i) begin
      case (fn_i)
        FN_COUNT: cnt_n = cnt_inc;
        FN_SUM, FN_AVG: begin
          if (!null_i) begin
            if (fn_i == FN_AVG) begin
              cnt_n = cnt_inc;
            end
            sum_n = sum_sat;
            hv_n  = 1'b1;
          end
        end
        FN_MIN, FN_MAX: begin
          if (!null_i) begin
            if (!old_hv ||
                ((fn_i == FN_MIN) && ($signed(value_i) < $signed(old_ext))) ||
                ((fn_i == FN_MAX) && ($signed(value_i) > $signed(old_ext)))) begin
              ext_n = value_i;
            end
            hv_n = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Restoring divider: (|sum| << 16) / count, one quotient bit a step.
  assign neg   = sum_q[63];
  assign trial = {rem_q, dq_q[79]};
  assign ge    = trial >= {1'b0, cnt_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      dq_q  <= {(neg ? (64'd0 - sum_q) : sum_q), 16'd0};
      rem_q <= 32'd0;
    end else if (ctrl_i.div_step) begin
      rem_q <= ge ? 32'(trial - {1'b0, cnt_q}) : trial[31:0];
      dq_q  <= {dq_q[78:0], ge};
    end
  end

  // Quotient clipped to the signed range, then signed.
  assign limit = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  assign mag_res = ((|dq_q[79:64]) || (dq_q[63:0] > limit)) ? limit : dq_q[63:0];

  // Final value of the slot.
  always_comb begin
    result_o = 64'd0;
    null_o   = 1'b0;
    if (active_i) begin
      case (fn_i)
        FN_COUNT: result_o = {32'd0, cnt_q};
        FN_SUM: begin
          if (hv_q) begin
            result_o = sum_q;
          end else begin
            null_o = 1'b1;
          end
        end
        FN_AVG: begin
          if (hv_q && (cnt_q != 32'd0)) begin
            result_o = neg ? (64'd0 - mag_res) : mag_res;
          end else begin
            null_o = 1'b1;
          end
        end
        FN_MIN, FN_MAX: begin
          if (hv_q) begin
            result_o = {{32{ext_q[31]}}, ext_q};
          end else begin
            null_o = 1'b1;
          end
        end
        default: null_o = 1'b1;
      endcase
    end
  end

endmodule : gba_slot_lane

`default_nettype wire

// ===== rtl/gba_checker.sv =====
// ----------------------------------------------------------------------------
// gba_checker
// Port-level checks of the group-by aggregation engine.
// ----------------------------------------------------------------------------
`default_nettype none

module gba_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        req_type_i,
  input wire logic        out_valid_o,
  input wire logic [1:0]  status_o,
  input wire logic [63:0] out_key_o,
  input wire logic        last_of_run_o
);
  import gba_pkg::*;

  // A row always occupies the engine for the following cycle.
  a_row_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_type_i == REQ_ROW)) |=> busy)
    else $error("row beat did not make the engine busy");

  // Status beats close their run.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_GROUP)) |-> (last_of_run_o && (out_key_o == 64'd0)))
    else $error("status beat not last or carries a key");

  // Group beats within a run are spaced by the divider.
  a_run_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_run_o) |=> !out_valid_o)
    else $error("back-to-back beats inside an emit run");

  // A run still in progress keeps the engine busy.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_run_o) |-> busy)
    else $error("engine idle in the middle of an emit run");

endmodule : gba_checker

bind group_by_aggregation_engine gba_checker u_gba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .req_type_i    (req_type_i),
  .out_valid_o   (out_valid_o),
  .status_o      (status_o),
  .out_key_o     (out_key_o),
  .last_of_run_o (last_of_run_o)
);

`default_nettype wire
